// ===== sv/base64_line_wrapped_encoder_assert.svh =====
// assertion macros for the line-wrapped base64 encoder
`ifndef BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAPPED_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define B64LW_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("b64lw assertion failed");

// next-cycle implication, disabled while dis is high
`define B64LW_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("b64lw assertion failed");

`endif

// ===== sv/b64lw_pkg.sv =====
package b64lw_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] LINE_LIMIT_RESET = 8'd72;
    localparam logic [CHAR_W-1:0] LF_CHAR          = 8'h0A;
    localparam logic [CHAR_W-1:0] PAD_CHAR         = 8'h3D;

    // position of the byte within its 3-byte group
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // standard alphabet lookup
    function automatic logic [CHAR_W-1:0] b64_sym(input logic [5:0] six);
        logic [CHAR_W-1:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            b64_sym = 8'h41 + v;
        end else if (six < 6'd52) begin
            b64_sym = 8'h61 + v - 8'd26;
        end else if (six < 6'd62) begin
            b64_sym = 8'h30 + v - 8'd52;
        end else if (six == 6'd62) begin
            b64_sym = 8'h2B;
        end else begin
            b64_sym = 8'h2F;
        end
    endfunction

endpackage

// ===== sv/base64_line_wrapped_encoder.sv =====
// Line-wrapped base64 encoder. Message bytes enter on the s_axis side, one
// per beat, with tlast on the final byte; encoded ASCII leaves on the m_axis
// side, one character per beat, with tlast on the final character of the
// message (always a line feed). Each byte yields one to five characters: one
// for the first and second byte of a group, two plus an optional line feed
// for the third, and at message end the pads and the closing line feed. The
// line limit (reset 72) must be written by the user through the cfg channel
// only while the block is idle; the block does not enforce this. The limit
// is checked only when a 4-character group completes. Timing: a byte is
// encoded in the cycle it is accepted into a five-entry character register,
// which drains one character per cycle into the output register while the
// output is not stalled; that single output character lane sets the rate.
// The next byte is taken in the cycle the last pending character moves to
// the output register, so consecutive bytes overlap with no bubble. A
// stalled output beat holds back the next byte only while characters are
// still pending; with none pending the byte still enters.
module base64_line_wrapped_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,       // line_limit
    // message bytes in
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // data_byte
    input  logic       i_s_axis_tlast,   // last_byte
    // encoded characters out
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_char
    output logic       o_m_axis_tlast    // message_done
);
    import b64lw_pkg::*;

    localparam int unsigned MAX_CHARS = 5;

    // group state carried between bytes
    logic [1:0]        r_phase;
    logic [3:0]        r_carry;
    logic [7:0]        r_line_count;
    logic [7:0]        r_line_limit;

    // pending characters of the current byte, head at index 0
    logic [CHAR_W-1:0] r_chars [MAX_CHARS];
    logic [2:0]        r_left;
    logic              r_msg_end;

    // output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    // encoder results for the byte on the input
    logic [CHAR_W-1:0] n_chars [MAX_CHARS];
    logic [2:0]        n_count;
    logic [1:0]        n_phase;
    logic [3:0]        n_carry;
    logic [7:0]        n_line_count;

    logic [8:0]        grp_count;
    logic              wrap;
    logic              pop;
    logic              accept;
    logic [7:0]        b;

    assign b = i_s_axis_tdata;

    // count after this group completes, compared against the limit
    assign grp_count = {1'b0, r_line_count} + 9'd4;
    assign wrap      = grp_count >= {1'b0, r_line_limit};

    always_comb begin
        for (int i = 0; i < MAX_CHARS; i++) begin
            n_chars[i] = LF_CHAR;
        end
        n_count      = 3'd1;
        n_phase      = r_phase;
        n_carry      = r_carry;
        n_line_count = r_line_count;
        case (r_phase)
            PHASE_SECOND: begin
                n_chars[0] = b64_sym({r_carry[1:0], b[7:4]});
                if (i_s_axis_tlast) begin
                    n_chars[1] = b64_sym({b[3:0], 2'b00});
                    n_chars[2] = PAD_CHAR;
                    n_chars[3] = LF_CHAR;
                    n_count    = 3'd4;
                end else begin
                    n_carry = b[3:0];
                    n_phase = PHASE_THIRD;
                end
            end
            PHASE_THIRD: begin
                n_chars[0] = b64_sym({r_carry, b[7:6]});
                n_chars[1] = b64_sym(b[5:0]);
                // a wrap line feed also closes the message; otherwise the
                // last byte adds its own line feed
                if (wrap || i_s_axis_tlast) begin
                    n_chars[2] = LF_CHAR;
                    n_count    = 3'd3;
                end else begin
                    n_count = 3'd2;
                end
                n_line_count = wrap ? 8'd0 : grp_count[7:0];
                n_carry      = 4'd0;
                n_phase      = PHASE_FIRST;
            end
            default: begin
                // first byte of a group, also the unused phase code
                n_chars[0] = b64_sym(b[7:2]);
                if (i_s_axis_tlast) begin
                    n_chars[1] = b64_sym({b[1:0], 4'b0000});
                    n_chars[2] = PAD_CHAR;
                    n_chars[3] = PAD_CHAR;
                    n_chars[4] = LF_CHAR;
                    n_count    = 3'd5;
                end else begin
                    n_carry = {2'b00, b[1:0]};
                    n_phase = PHASE_SECOND;
                end
            end
        endcase
        // message end returns the group state to its reset value
        if (i_s_axis_tlast) begin
            n_phase      = PHASE_FIRST;
            n_carry      = 4'd0;
            n_line_count = 8'd0;
        end
    end

    // move the head character on when the output register frees up
    assign pop    = (r_left != 3'd0) && (!r_out_valid || i_m_axis_tready);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_left == 3'd0) || ((r_left == 3'd1) && pop);
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PHASE_FIRST;
            r_carry      <= 4'd0;
            r_line_count <= 8'd0;
            r_line_limit <= LINE_LIMIT_RESET;
            r_left       <= 3'd0;
            r_msg_end    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_limit <= i_cfg_data;
            end

            if (pop) begin
                r_out_valid <= 1'b1;
                r_out_char  <= r_chars[0];
                r_out_last  <= r_msg_end && (r_left == 3'd1);
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                r_chars      <= n_chars;
                r_left       <= n_count;
                r_msg_end    <= i_s_axis_tlast;
                r_phase      <= n_phase;
                r_carry      <= n_carry;
                r_line_count <= n_line_count;
            end else if (pop) begin
                for (int i = 0; i < MAX_CHARS - 1; i++) begin
                    r_chars[i] <= r_chars[i+1];
                end
                r_left <= r_left - 3'd1;
            end
        end
    end

endmodule

// ===== sv/b64lw_checker.sv =====
`include "base64_line_wrapped_encoder_assert.svh"

module b64lw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [7:0] i_cfg_data,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);
    import b64lw_pkg::*;

    logic out_is_sym;
    logic unused_in;

    assign out_is_sym =
        (o_m_axis_tdata >= 8'h41 && o_m_axis_tdata <= 8'h5A) ||
        (o_m_axis_tdata >= 8'h61 && o_m_axis_tdata <= 8'h7A) ||
        (o_m_axis_tdata >= 8'h30 && o_m_axis_tdata <= 8'h39) ||
        o_m_axis_tdata == 8'h2B || o_m_axis_tdata == 8'h2F ||
        o_m_axis_tdata == PAD_CHAR || o_m_axis_tdata == LF_CHAR;

    assign unused_in = ^{i_cfg_valid, o_cfg_ready, i_cfg_data, i_s_axis_tvalid,
                         o_s_axis_tready, i_s_axis_tdata, i_s_axis_tlast};

    // a stalled output beat holds
    `B64LW_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    // only alphabet symbols, pads and line feeds leave the block
    `B64LW_ASSERT_IMPLY(a_char_set, i_clk, !i_rst_n, o_m_axis_tvalid, out_is_sym)
    // every message closes on a line feed
    `B64LW_ASSERT_IMPLY(a_last_is_lf, i_clk, !i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata == LF_CHAR)
    // nothing is offered straight after reset
    `B64LW_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind base64_line_wrapped_encoder b64lw_checker u_b64lw_checker (.*);
